// ===== sv/psrm_pkg.sv =====
// ----------------------------------------------------------------------------
// psrm_pkg: shared types and constants for the Prony series modulus core
// Fixed-point formats, per-term build constants and register indexes.
// ----------------------------------------------------------------------------
package psrm_pkg;

  // default number of series lanes
  localparam int MAX_TERMS_DEF = 4;

  // payload widths
  localparam int TIME_W  = 32;
  localparam int TEMP_W  = 16;
  localparam int MOIST_W = 16;
  localparam int MOD_W   = 32;

  // reduced-time magnitude, Q16 seconds scaled, after the >>16
  localparam int BASE_W = 83;
  // exponent magnitude, Q16, capped at 64.0
  localparam int X_W = 23;
  localparam logic [X_W-1:0] XCAP = 23'h40_0000;
  // log2(e) and ln(2) in Q30
  localparam logic [30:0] L2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  // Horner evaluation of exp(z), ten steps
  localparam int HORNER_STEPS = 10;
  localparam int RECIP_SHIFT  = 34;
  localparam int E_W   = 24;
  localparam int INV_W = 64;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TEMP_SLOPE  = 3'd0,
    REG_REF_TEMP    = 3'd1,
    REG_MOIST_SLOPE = 3'd2,
    REG_REF_MOIST   = 3'd3,
    REG_TERMS       = 3'd4
  } reg_idx_t;

  // control travelling with a word into a term lane
  typedef struct packed {
    logic vld;
    logic growth;
  } lane_ctl_t;

  // result of one term lane
  typedef struct packed {
    logic             vld;
    logic             sat;
    logic [MOD_W-1:0] term;
  } term_res_t;

  // modulus of term i in Pa; slots past the built-in four are zero
  function automatic logic [E_W-1:0] term_modulus(input int i);
    case (i)
      0:       return 24'd660000;
      1:       return 24'd1800000;
      2:       return 24'd2500000;
      3:       return 24'd12000000;
      default: return '0;
    endcase
  endfunction

  // floor((2^64-1)/tau_i); slots past the built-in four have tau = 1
  function automatic logic [INV_W-1:0] term_inv_tau(input int i);
    case (i)
      0:       return 64'd40014629227;
      1:       return 64'd330586811356;
      2:       return 64'd13974806116446;
      3:       return 64'd118248359446856;
      default: return 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

endpackage

// ===== sv/psrm_if.sv =====
// ----------------------------------------------------------------------------
// psrm_sample_if / psrm_result_if: valid/ready channels of the modulus core
// One word per handshake; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface psrm_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] elapsed_time;
  logic [15:0] temperature;
  logic [15:0] moisture;

  modport source (output valid, output elapsed_time, output temperature,
                  output moisture, input ready);
  modport sink   (input valid, input elapsed_time, input temperature,
                  input moisture, output ready);
endinterface

interface psrm_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] modulus;
  logic        saturated;

  modport source (output valid, output modulus, output saturated, input ready);
  modport sink   (input valid, input modulus, input saturated, output ready);
endinterface

// ===== sv/psrm_term.sv =====
// ----------------------------------------------------------------------------
// psrm_term: one series term E*exp(-tr/tau)
// Scales the reduced time by 1/tau, converts to a power of two, evaluates
// the fractional part by a pipelined Horner series and scales by E.
// ----------------------------------------------------------------------------
module psrm_term #(
  parameter int LANE = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  psrm_pkg::lane_ctl_t      ctl_i,
  input  logic [psrm_pkg::BASE_W-1:0] base_i,
  output psrm_pkg::term_res_t      res_o
);
  import psrm_pkg::*;

  localparam logic [INV_W-1:0] INV  = term_inv_tau(LANE);
  localparam logic [E_W-1:0]   EMOD = term_modulus(LANE);
  localparam logic [31:0]      INV_LO = INV[31:0];
  localparam logic [31:0]      INV_HI = INV[63:32];

  typedef struct packed {
    logic        vld;
    logic        growth;
    logic [7:0]  k2;
    logic [29:0] z;
  } hctl_t;

  // ---- L1: partial products of base * (1/tau)
  lane_ctl_t   c1;
  logic [59:0] pp00, pp01, pp10, pp11;
  logic [58:0] pp20, pp21;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.vld <= 1'b0;
    end else if (en) begin
      c1 <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= base_i[27:0] * INV_LO;
      pp01 <= base_i[27:0] * INV_HI;
      pp10 <= base_i[55:28] * INV_LO;
      pp11 <= base_i[55:28] * INV_HI;
      pp20 <= base_i[82:56] * INV_LO;
      pp21 <= base_i[82:56] * INV_HI;
    end
  end

  // ---- L2: fold the 32-bit halves of the reciprocal
  lane_ctl_t   c2;
  logic [92:0] s0, s1, s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2.vld <= 1'b0;
    end else if (en) begin
      c2 <= c1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= 93'(pp00) + (93'(pp01) << 32);
      s1 <= 93'(pp10) + (93'(pp11) << 32);
      s2 <= 93'(pp20) + (93'(pp21) << 32);
    end
  end

  // ---- L3: first and second chunks
  lane_ctl_t    c3;
  logic [121:0] acc;
  logic [92:0]  s2_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      c3.vld <= 1'b0;
    end else if (en) begin
      c3 <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc  <= 122'(s0) + (122'(s1) << 28);
      s2_d <= s2;
    end
  end

  // ---- L4: full product, take bits 79 and up, cap at 64.0
  lane_ctl_t    c4;
  logic [147:0] full;
  logic [68:0]  x_raw;
  logic [X_W-1:0] x_next, x;

  assign full   = 148'(acc) + (148'(s2_d) << 56);
  assign x_raw  = full[147:79];
  assign x_next = (x_raw > 69'(XCAP)) ? XCAP : x_raw[X_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      c4.vld <= 1'b0;
    end else if (en) begin
      c4 <= c3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x <= x_next;
    end
  end

  // ---- L5: y = x*log2(e), Q16
  lane_ctl_t   c5;
  logic [53:0] y_prod;
  logic [23:0] y;

  assign y_prod = x * L2E_Q30;

  always_ff @(posedge clk) begin
    if (rst) begin
      c5.vld <= 1'b0;
    end else if (en) begin
      c5 <= c4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= y_prod[53:30];
    end
  end

  // ---- L6: split integer/fraction, pick fraction side, z = f*ln2
  logic [7:0]  yk;
  logic [15:0] yu, f;
  logic [7:0]  k2_next;
  logic [45:0] z_prod;
  hctl_t       h0;

  assign yk      = y[23:16];
  assign yu      = y[15:0];
  assign f       = c5.growth ? yu : ((yu == '0) ? '0 : 16'(17'h1_0000 - 17'(yu)));
  assign k2_next = (c5.growth || yu == '0) ? yk : yk + 8'd1;
  assign z_prod  = f * LN2_Q30;

  always_ff @(posedge clk) begin
    if (rst) begin
      h0.vld <= 1'b0;
    end else if (en) begin
      h0.vld <= c5.vld;
    end
    if (en) begin
      h0.growth <= c5.growth;
      h0.k2     <= k2_next;
      h0.z      <= z_prod[45:16];
    end
  end

  // ---- Horner: r = 1 + z*r/k for k = 10 down to 1, three stages a step
  hctl_t       hc [HORNER_STEPS+1];
  logic [30:0] hr [HORNER_STEPS+1];

  assign hc[0] = h0;
  assign hr[0] = Q30_ONE;

  for (genvar s = 0; s < HORNER_STEPS; s++) begin : g_horner
    localparam int DIV = HORNER_STEPS - s;
    localparam logic [34:0] RECIP = 35'((64'd1 << RECIP_SHIFT) / DIV);

    hctl_t       ca, cb;
    logic [60:0] zr;
    logic [30:0] va, vb;
    logic [65:0] qm;
    logic [31:0] q_est, rem, q_fix;

    // multiply by z, back to Q30
    assign zr = hc[s].z * hr[s];

    always_ff @(posedge clk) begin
      if (rst) begin
        ca.vld <= 1'b0;
        cb.vld <= 1'b0;
        hc[s+1].vld <= 1'b0;
      end else if (en) begin
        ca <= hc[s];
        cb <= ca;
        hc[s+1] <= cb;
      end
    end

    // divide by the step constant: reciprocal multiply, one correction
    assign q_est = qm[65:34];
    assign rem   = 32'(vb) - 32'(q_est * 32'(DIV));
    assign q_fix = (rem >= 32'(DIV)) ? q_est + 32'd1 : q_est;

    always_ff @(posedge clk) begin
      if (en) begin
        va <= zr[60:30];
        vb <= va;
        qm <= va * RECIP;
        hr[s+1] <= 31'(32'(Q30_ONE) + q_fix);
      end
    end
  end

  // ---- scale by modulus
  hctl_t       ce;
  logic [54:0] m;

  always_ff @(posedge clk) begin
    if (rst) begin
      ce.vld <= 1'b0;
    end else if (en) begin
      ce <= hc[HORNER_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m <= EMOD * hr[HORNER_STEPS];
    end
  end

  // ---- apply the power of two: growth shifts up and clamps, decay shifts down
  logic [63:0] m64, gsh, dsh;
  logic [7:0]  dsh_amt;
  logic [5:0]  gsh_amt;
  term_res_t   res_next;

  assign m64     = 64'(m);
  assign gsh_amt = 6'(8'd30 - ce.k2);
  assign gsh     = (ce.k2 <= 8'd30) ? (m64 >> gsh_amt) : (m64 << 1);
  assign dsh_amt = 8'd30 + ce.k2;
  assign dsh     = m64 >> dsh_amt[5:0];

  always_comb begin
    res_next.vld  = ce.vld;
    res_next.sat  = 1'b0;
    res_next.term = '0;
    if (ce.growth) begin
      if (ce.k2 >= 8'd32 || gsh > 64'hFFFF_FFFF) begin
        res_next.term = '1;
        res_next.sat  = 1'b1;
      end else begin
        res_next.term = gsh[31:0];
      end
    end else if (ce.k2 < 8'd34) begin
      res_next.term = dsh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_o.vld <= 1'b0;
    end else if (en) begin
      res_o <= res_next;
    end
  end

endmodule

// ===== sv/prony_series_relaxation_modulus_core.sv =====
// ----------------------------------------------------------------------------
// prony_series_relaxation_modulus_core: generalized Maxwell relaxation modulus
// Forms shift factors and reduced time, evaluates each series term in its
// own lane and sums the terms in use with saturation.
//
//   channel  role   handshake        payload
//   sample   sink   valid/ready      elapsed_time, temperature, moisture
//   result   source valid/ready      modulus, saturated
//   apb      slave  psel/penable     5 registers at 4*i; user writes only when idle, unchecked by the core
//
// One word enters per cycle while the result register is empty or taken; the pipeline
// has 7 front stages, 38 lane stages and 2 summing stages. The 32-bit multiplier slices
// of the reduced-time product and the ten Horner steps of each lane set the depth.
// rst is synchronous and clears valid bits and the configuration registers to defaults.
// A stalled result freezes the whole pipeline; no word is lost or repeated.
// ----------------------------------------------------------------------------
module prony_series_relaxation_modulus_core #(
  parameter int MAX_TERMS = psrm_pkg::MAX_TERMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  psrm_sample_if.sink   sample,
  psrm_result_if.source result
);
  import psrm_pkg::*;

  localparam int NGRP = (MAX_TERMS + 3) / 4;

  // ---- configuration registers
  logic signed [15:0] temp_shift_slope;
  logic [15:0]        ref_temp;
  logic signed [20:0] moist_shift_slope;
  logic [15:0]        ref_moisture;
  logic [2:0]         terms_in_use;
  reg_idx_t           reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_shift_slope  <= -16'sd852;
      ref_temp          <= 16'd38144;
      moist_shift_slope <= -21'sd18688;
      ref_moisture      <= 16'd9175;
      terms_in_use      <= 3'd4;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TEMP_SLOPE:  temp_shift_slope  <= pwdata[15:0];
        REG_REF_TEMP:    ref_temp          <= pwdata[15:0];
        REG_MOIST_SLOPE: moist_shift_slope <= pwdata[20:0];
        REG_REF_MOIST:   ref_moisture      <= pwdata[15:0];
        REG_TERMS:       terms_in_use      <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TEMP_SLOPE:  prdata = 32'(unsigned'(temp_shift_slope));
      REG_REF_TEMP:    prdata = 32'(ref_temp);
      REG_MOIST_SLOPE: prdata = 32'(unsigned'(moist_shift_slope));
      REG_REF_MOIST:   prdata = 32'(ref_moisture);
      REG_TERMS:       prdata = 32'(terms_in_use);
      default:         prdata = '0;
    endcase
  end

  // ---- pipeline advance
  logic en;
  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  // ---- T1: offsets from the reference point
  logic               v1;
  logic [31:0]        t1;
  logic signed [16:0] dt, dm;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= sample.elapsed_time;
      dt <= signed'(17'(sample.temperature) - 17'(ref_temp));
      dm <= signed'(17'(sample.moisture) - 17'(ref_moisture));
    end
  end

  // ---- T2: shift factors
  logic               v2;
  logic [31:0]        t2;
  logic signed [32:0] a_next, a;
  logic signed [37:0] b_next, b;

  assign a_next = temp_shift_slope * dt;
  assign b_next = moist_shift_slope * dm;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2 <= t1;
      a  <= a_next;
      b  <= b_next;
    end
  end

  // ---- T3: magnitudes and direction
  logic        v3, g3;
  logic [31:0] t3;
  logic [32:0] a_mag;
  logic [37:0] b_mag;
  logic [30:0] am;
  logic [35:0] bm;

  assign a_mag = a[32] ? 33'(-a) : 33'(a);
  assign b_mag = b[37] ? 38'(-b) : 38'(b);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3 <= t2;
      am <= a_mag[30:0];
      bm <= b_mag[35:0];
      g3 <= (a[32] != b[37]) && (a != '0) && (b != '0);
    end
  end

  // ---- T4: aT*aM partial products
  logic        v4, g4;
  logic [31:0] t4;
  logic [62:0] pab_lo;
  logic [34:0] pab_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4     <= t3;
      g4     <= g3;
      pab_lo <= am * bm[31:0];
      pab_hi <= am * bm[35:32];
    end
  end

  // ---- T5: aT*aM
  logic        v5, g5;
  logic [31:0] t5;
  logic [66:0] ab;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t5 <= t4;
      g5 <= g4;
      ab <= 67'(pab_lo) + (67'(pab_hi) << 32);
    end
  end

  // ---- T6: times elapsed time, partial products
  logic        v6, g6;
  logic [63:0] q0, q1;
  logic [34:0] q2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g6 <= g5;
      q0 <= ab[31:0] * t5;
      q1 <= ab[63:32] * t5;
      q2 <= ab[66:64] * t5;
    end
  end

  // ---- T7: reduced-time magnitude, drop 16 fraction bits
  lane_ctl_t          ctl7;
  logic [98:0]        p_full;
  logic [BASE_W-1:0]  base;

  assign p_full = 99'(q0) + (99'(q1) << 32) + (99'(q2) << 64);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl7.vld <= 1'b0;
    end else if (en) begin
      ctl7.vld <= v6;
    end
    if (en) begin
      ctl7.growth <= g6;
      base        <= p_full[98:16];
    end
  end

  // ---- term lanes
  term_res_t lane_res [MAX_TERMS];

  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_lane
    psrm_term #(.LANE(i)) u_term (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctl_i  (ctl7),
      .base_i (base),
      .res_o  (lane_res[i])
    );
  end

  // ---- G1: group sums over up to four lanes in use
  logic        vg;
  logic [33:0] gsum [NGRP];
  logic        gsat [NGRP];

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    logic [33:0] sum_next;
    logic        sat_next;

    always_comb begin
      sum_next = '0;
      sat_next = 1'b0;
      for (int j = 0; j < 4; j++) begin
        if (g * 4 + j < MAX_TERMS) begin
          if (5'(g * 4 + j) < 5'(terms_in_use)) begin
            sum_next = sum_next + 34'(lane_res[g * 4 + j].term);
            sat_next = sat_next | lane_res[g * 4 + j].sat;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        gsum[g] <= sum_next;
        gsat[g] <= sat_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (en) begin
      vg <= lane_res[0].vld;
    end
  end

  // ---- G2: total with clamp, into the output register
  logic [35:0] total;
  logic        any_sat;

  always_comb begin
    total   = '0;
    any_sat = 1'b0;
    for (int g = 0; g < NGRP; g++) begin
      total   = total + 36'(gsum[g]);
      any_sat = any_sat | gsat[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= vg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.modulus   <= (total > 36'hFFFF_FFFF) ? '1 : total[31:0];
      result.saturated <= any_sat || (total > 36'hFFFF_FFFF);
    end
  end

`ifndef SYNTHESIS
  // a saturated word always carries the clamp value
  a_sat_clamps: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.saturated |-> result.modulus == 32'hFFFF_FFFF)
    else $error("saturated word without clamped modulus");

  // with no terms in use the sum is empty
  a_zero_terms: assert property (@(posedge clk) disable iff (rst)
    result.valid && terms_in_use == 3'd0 |-> result.modulus == '0 && !result.saturated)
    else $error("nonzero modulus with no terms in use");

  // reset leaves no word in the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");
`endif

endmodule
